>>> sv/ffln_pkg.sv
// shared types and constants of the flat-field log normalize unit
`default_nettype none
package ffln_pkg;

  // default line length
  localparam int unsigned MAX_PIXELS_DEF = 4096;

  // log2 unit sizing
  localparam int unsigned LOG_XW    = 50;
  localparam int unsigned LOG_EW    = 6;
  localparam int unsigned LOG_ITERS = 24;
  localparam int unsigned LOG_LW    = LOG_EW + LOG_ITERS;

  // ln(2) in Q.32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // item kinds
  typedef enum logic [1:0] {
    FUNC_DARK        = 2'd0,
    FUNC_FLAT_BEFORE = 2'd1,
    FUNC_FLAT_AFTER  = 2'd2,
    FUNC_PROJ        = 2'd3
  } func_e;

  // result status
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BLACK   = 2'd1,
    ST_BAD_REF = 2'd2
  } status_e;

  // sideband that follows an item down the pipeline
  typedef struct packed {
    logic    valid;
    status_e status;
    logic    last;
  } side_t;

endpackage
`default_nettype wire

>>> sv/flat_field_log_normalize_unit.sv
// top level of the flat-field log normalize unit
// throughput: one pixel per cycle while in_stall_o is low; the log2 units are 26-stage pipelines
// stores take effect in order, so a projection right after a store sees it
// reset clears all valid bits and both flat times; line stores start undefined
`default_nettype none
module flat_field_log_normalize_unit #(
  parameter int unsigned MAX_PIXELS = ffln_pkg::MAX_PIXELS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [11:0] pixel_index_i,
  input  wire logic [15:0] pixel_value_i,
  input  wire logic [31:0] shot_time_i,
  input  wire logic        last_in_row_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [23:0]      attenuation_o,
  output logic [1:0]       pixel_status_o,
  output logic             last_of_row_o
);

  localparam int unsigned AW  = $clog2(MAX_PIXELS);
  localparam int unsigned LW  = ffln_pkg::LOG_LW;
  localparam int unsigned LAT = ffln_pkg::LOG_ITERS + 2;

  logic skid_v_q;
  logic en;
  assign en = !skid_v_q;
  assign in_stall_o = !en;

  // stage 1: input register
  logic        v1_q, last1_q;
  logic [1:0]  func1_q;
  logic [11:0] idx1_q;
  logic [15:0] val1_q;
  logic [31:0] t1_q;
  logic        ok1;
  logic [AW-1:0] addr1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      func1_q <= func_i;
      idx1_q  <= pixel_index_i;
      val1_q  <= pixel_value_i;
      t1_q    <= shot_time_i;
      last1_q <= last_in_row_i;
    end
  end

  assign ok1   = 32'(idx1_q) < 32'(MAX_PIXELS);
  assign addr1 = AW'(idx1_q);

  // line stores and flat times
  logic [15:0] dk_rd, fb_rd, fa_rd;
  logic [31:0] tb_q, ta_q;

  ffln_line_store #(.DEPTH(MAX_PIXELS)) u_dark (
    .clk_i, .en_i(en),
    .we_i(v1_q && ok1 && func1_q == ffln_pkg::FUNC_DARK),
    .addr_i(addr1), .wdata_i(val1_q), .rdata_o(dk_rd)
  );
  ffln_line_store #(.DEPTH(MAX_PIXELS)) u_flat_before (
    .clk_i, .en_i(en),
    .we_i(v1_q && ok1 && func1_q == ffln_pkg::FUNC_FLAT_BEFORE),
    .addr_i(addr1), .wdata_i(val1_q), .rdata_o(fb_rd)
  );
  ffln_line_store #(.DEPTH(MAX_PIXELS)) u_flat_after (
    .clk_i, .en_i(en),
    .we_i(v1_q && ok1 && func1_q == ffln_pkg::FUNC_FLAT_AFTER),
    .addr_i(addr1), .wdata_i(val1_q), .rdata_o(fa_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tb_q <= '0;
      ta_q <= '0;
    end else if (en && v1_q) begin
      if (func1_q == ffln_pkg::FUNC_FLAT_BEFORE) begin
        tb_q <= t1_q;
      end
      if (func1_q == ffln_pkg::FUNC_FLAT_AFTER) begin
        ta_q <= t1_q;
      end
    end
  end

  // stage 2: store read data, only projections go on
  logic        v2_q, ok2_q, last2_q;
  logic [15:0] val2_q;
  logic [31:0] t2_q, tb2_q, ta2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q && func1_q == ffln_pkg::FUNC_PROJ;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok2_q   <= ok1;
      last2_q <= last1_q;
      val2_q  <= val1_q;
      t2_q    <= t1_q;
      tb2_q   <= tb_q;
      ta2_q   <= ta_q;
    end
  end

  // stage 3: dark subtraction and time differences
  logic [15:0]        dk2, fb2, fa2;
  logic signed [16:0] c_d, f1_d, f2_d;
  logic signed [32:0] a_d, b_d, den_d;
  logic               v3_q, last3_q, eq3_q, black3_q;
  logic signed [16:0] c3_q, f13_q, f23_q;
  logic signed [32:0] a3_q, b3_q, den3_q;

  assign dk2   = ok2_q ? dk_rd : 16'd0;
  assign fb2   = ok2_q ? fb_rd : 16'd0;
  assign fa2   = ok2_q ? fa_rd : 16'd0;
  assign c_d   = $signed({1'b0, val2_q}) - $signed({1'b0, dk2});
  assign f1_d  = $signed({1'b0, fb2}) - $signed({1'b0, dk2});
  assign f2_d  = $signed({1'b0, fa2}) - $signed({1'b0, dk2});
  assign a_d   = $signed({1'b0, ta2_q}) - $signed({1'b0, t2_q});
  assign b_d   = $signed({1'b0, t2_q}) - $signed({1'b0, tb2_q});
  assign den_d = $signed({1'b0, ta2_q}) - $signed({1'b0, tb2_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last3_q  <= last2_q;
      eq3_q    <= tb2_q == ta2_q;
      black3_q <= c_d < 17'sd1;
      c3_q     <= c_d;
      f13_q    <= f1_d;
      f23_q    <= f2_d;
      a3_q     <= a_d;
      b3_q     <= b_d;
      den3_q   <= den_d;
    end
  end

  // stage 4: interpolation products and denominator times count
  logic signed [49:0] p1_d, p2_d;
  logic [32:0]        dabs33;
  logic [47:0]        dc_d;
  logic               v4_q, last4_q, eq4_q, black4_q, neg4_q;
  logic signed [49:0] p14_q, p24_q;
  logic signed [16:0] f14_q;
  logic [47:0]        dc4_q;

  assign p1_d   = f13_q * a3_q;
  assign p2_d   = f23_q * b3_q;
  assign dabs33 = den3_q[32] ? 33'(-den3_q) : 33'(den3_q);
  assign dc_d   = eq3_q ? 48'(c3_q[15:0]) : dabs33[31:0] * c3_q[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last4_q  <= last3_q;
      eq4_q    <= eq3_q;
      black4_q <= black3_q;
      neg4_q   <= den3_q[32];
      p14_q    <= p1_d;
      p24_q    <= p2_d;
      f14_q    <= f13_q;
      dc4_q    <= dc_d;
    end
  end

  // stage 5: reference numerator and status
  logic [50:0]           sum_d, num_d;
  logic                  bad_d;
  ffln_pkg::status_e     st_d;
  ffln_pkg::side_t       side5_q;
  logic [ffln_pkg::LOG_XW-1:0] xn5_q, xd5_q;

  assign sum_d = {p14_q[49], p14_q} + {p24_q[49], p24_q};
  assign num_d = eq4_q ? {{34{f14_q[16]}}, f14_q} : (neg4_q ? -sum_d : sum_d);
  assign bad_d = num_d[50] || num_d == 51'd0;

  always_comb begin
    if (black4_q) begin
      st_d = ffln_pkg::ST_BLACK;
    end else if (bad_d) begin
      st_d = ffln_pkg::ST_BAD_REF;
    end else begin
      st_d = ffln_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side5_q <= '0;
    end else if (en) begin
      side5_q <= '{valid: v4_q, status: st_d, last: last4_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xn5_q <= num_d[ffln_pkg::LOG_XW-1:0];
      xd5_q <= ffln_pkg::LOG_XW'(dc4_q);
    end
  end

  // log2 of numerator and of denominator times count
  logic [LW-1:0] ln_log, ld_log;

  ffln_log2 u_log_num (.clk_i, .en_i(en), .x_i(xn5_q), .log_o(ln_log));
  ffln_log2 u_log_den (.clk_i, .en_i(en), .x_i(xd5_q), .log_o(ld_log));

  // sideband follows the log pipelines
  ffln_pkg::side_t sd_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) begin
        sd_q[i] <= '0;
      end
    end else if (en) begin
      sd_q[0] <= side5_q;
      for (int i = 1; i < LAT; i++) begin
        sd_q[i] <= sd_q[i-1];
      end
    end
  end

  // log difference
  logic signed [LW:0] d_d, dd_q;
  ffln_pkg::side_t    sdd_q;

  assign d_d = $signed({1'b0, ln_log}) - $signed({1'b0, ld_log});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sdd_q <= '0;
    end else if (en) begin
      sdd_q <= sd_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dd_q <= d_d;
    end
  end

  // scale by ln(2)
  logic [LW:0]     dmag;
  logic [LW+32:0]  mag_d, mag_q;
  logic            negm_q;
  ffln_pkg::side_t sdm_q;

  assign dmag  = dd_q[LW] ? (LW+1)'(-dd_q) : (LW+1)'(dd_q);
  assign mag_d = dmag * ffln_pkg::LN2_Q32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sdm_q <= '0;
    end else if (en) begin
      sdm_q <= sdd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q  <= mag_d;
      negm_q <= dd_q[LW];
    end
  end

  // round to Q8.16 and saturate
  logic [63:0] qsum;
  logic [23:0] q, qc, att_d;

  assign qsum = 64'(mag_q) + (64'd1 << 39);
  assign q    = qsum[63:40];
  assign qc   = (q > 24'h800000) ? 24'h800000 : q;

  always_comb begin
    if (sdm_q.status != ffln_pkg::ST_OK) begin
      att_d = '0;
    end else if (!negm_q && qc == 24'h800000) begin
      att_d = 24'h7FFFFF;
    end else begin
      att_d = negm_q ? -qc : qc;
    end
  end

  // output register with skid stage
  logic        out_v_q, take;
  logic [23:0] out_att_q, skid_att_q;
  logic [1:0]  out_st_q, skid_st_q;
  logic        out_last_q, skid_last_q;
  logic        load_out, load_skid, from_skid;

  assign take      = out_v_q && !out_stall_i;
  assign from_skid = (take || !out_v_q) && skid_v_q;
  assign load_out  = (take || !out_v_q) && !skid_v_q && en && sdm_q.valid;
  assign load_skid = out_v_q && !take && en && sdm_q.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (take || !out_v_q) begin
        out_v_q <= skid_v_q || (en && sdm_q.valid);
        if (skid_v_q) begin
          skid_v_q <= 1'b0;
        end
      end else if (load_skid) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (from_skid) begin
      out_att_q  <= skid_att_q;
      out_st_q   <= skid_st_q;
      out_last_q <= skid_last_q;
    end else if (load_out) begin
      out_att_q  <= att_d;
      out_st_q   <= sdm_q.status;
      out_last_q <= sdm_q.last;
    end
    if (load_skid) begin
      skid_att_q  <= att_d;
      skid_st_q   <= sdm_q.status;
      skid_last_q <= sdm_q.last;
    end
  end

  assign out_valid_o    = out_v_q;
  assign attenuation_o  = out_att_q;
  assign pixel_status_o = out_st_q;
  assign last_of_row_o  = out_last_q;

`ifndef SYNTHESIS
  // skid stage only holds data behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds data while output register is empty");

  // skid fills only when the output was held
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid filled without a stalled output");

  // flagged pixels carry zero attenuation
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_status_o != ffln_pkg::ST_OK |-> attenuation_o == 24'd0)
    else $error("flagged pixel with nonzero attenuation");
`endif

endmodule
`default_nettype wire

>>> sv/ffln_line_store.sv
// one detector line store with registered read
`default_nettype none
module ffln_line_store #(
  parameter int unsigned DEPTH = ffln_pkg::MAX_PIXELS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [15:0]              wdata_i,
  output logic      [15:0]              rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  // write and read advance with the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> sv/ffln_log2.sv
// pipelined log2 in Q.24: msb search, normalize, one squaring step per stage
`default_nettype none
module ffln_log2 (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic [ffln_pkg::LOG_XW-1:0]     x_i,
  output logic      [ffln_pkg::LOG_LW-1:0]     log_o
);

  localparam int unsigned XW = ffln_pkg::LOG_XW;
  localparam int unsigned EW = ffln_pkg::LOG_EW;
  localparam int unsigned NI = ffln_pkg::LOG_ITERS;

  logic [XW-1:0]    x_q;
  logic [EW-1:0]    e_d, e_q;
  logic [XW+29:0]   sh;
  logic [31:0]      s_c [NI];
  logic [30:0]      m_q [NI+1];
  logic [NI-1:0]    f_q [NI+1];
  logic [EW-1:0]    ex_q [NI+1];

  // msb position
  always_comb begin
    e_d = '0;
    for (int i = 0; i < XW; i++) begin
      if (x_i[i]) begin
        e_d = EW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_i;
      e_q <= e_d;
    end
  end

  // normalize mantissa to Q1.30
  assign sh = {x_q, 30'b0} >> e_q;

  // squared mantissa of each stage, back in Q2.30
  always_comb begin
    logic [61:0] sq;
    sq = '0;
    for (int k = 0; k < NI; k++) begin
      sq = m_q[k] * m_q[k];
      s_c[k] = sq[61:30];
    end
  end

  // squaring steps, one fraction bit each
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]  <= sh[30:0];
      f_q[0]  <= '0;
      ex_q[0] <= e_q;
      for (int k = 0; k < NI; k++) begin
        m_q[k+1]  <= s_c[k][31] ? s_c[k][31:1] : s_c[k][30:0];
        f_q[k+1]  <= {f_q[k][NI-2:0], s_c[k][31]};
        ex_q[k+1] <= ex_q[k];
      end
    end
  end

  assign log_o = {ex_q[NI], f_q[NI]};

endmodule
`default_nettype wire

>>> tb/sv/tb_flat_field_log_normalize_unit.sv
// testbench of the flat-field log normalize unit: directed and random pixel streams, self-checked
`default_nettype none
module tb_flat_field_log_normalize_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_LEN    = 4096;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam longint      ATT_HI      = 64'sd8388607;
  localparam longint      ATT_LO      = -64'sd8388608;

  typedef struct packed {
    logic [23:0]       att;
    ffln_pkg::status_e status;
    logic              last;
  } atten_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = '0;
  logic [11:0] pixel_index_i = '0;
  logic [15:0] pixel_value_i = '0;
  logic [31:0] shot_time_i = '0;
  logic        last_in_row_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [23:0] attenuation_o;
  logic [1:0]  pixel_status_o;
  logic        last_of_row_o;

  // model copy of the line stores and flat times
  logic [15:0] dark_px [LINE_LEN];
  logic [15:0] flat1_px [LINE_LEN];
  logic [15:0] flat2_px [LINE_LEN];
  bit          dark_set [LINE_LEN];
  bit          flat1_set [LINE_LEN];
  bit          flat2_set [LINE_LEN];
  bit          in_ready_pool [LINE_LEN];
  logic [11:0] ready_idx [$];
  logic [31:0] t_flat1 = '0;
  logic [31:0] t_flat2 = '0;

  atten_t      atten_q [$];
  int unsigned mismatches = 0;
  int unsigned n_proj = 0;
  int unsigned n_store = 0;
  int unsigned n_checked = 0;
  int unsigned n_black = 0;
  int unsigned n_badref = 0;
  int unsigned cycles = 0;
  bit          send_gaps = 1'b1;
  bit          recv_stalls = 1'b1;
  bit          long_hold = 1'b0;

  flat_field_log_normalize_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .pixel_index_i (pixel_index_i),
    .pixel_value_i (pixel_value_i),
    .shot_time_i   (shot_time_i),
    .last_in_row_i (last_in_row_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .attenuation_o (attenuation_o),
    .pixel_status_o(pixel_status_o),
    .last_of_row_o (last_of_row_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // log2 in Q.24 by repeated squaring of the normalized mantissa
  function automatic longint log2_q24(longint unsigned x);
    int             e;
    longint unsigned m;
    longint         frac;
    e = 63;
    frac = 0;
    while (e > 0 && x[e] == 1'b0) e--;
    if (e > 30) m = x >> (e - 30);
    else m = x << (30 - e);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(e) * (64'sd1 << 24) + frac;
  endfunction

  // expected attenuation of one projection pixel
  function automatic atten_t attenuation_of(logic [11:0] idx, logic [15:0] val,
                                            logic [31:0] t, logic last);
    atten_t          r;
    longint          dk, c, f1, f2, num, den, d, att;
    longint unsigned mag, q;
    bit              neg;
    dk = longint'(dark_px[idx]);
    f1 = longint'(flat1_px[idx]) - dk;
    f2 = longint'(flat2_px[idx]) - dk;
    c = longint'(val) - dk;
    att = 0;
    r.status = ffln_pkg::ST_OK;
    r.last = last;
    if (c < 1) begin
      r.status = ffln_pkg::ST_BLACK;
    end else begin
      if (t_flat1 == t_flat2) begin
        num = f1;
        den = 1;
      end else begin
        den = longint'(t_flat2) - longint'(t_flat1);
        num = f1 * (longint'(t_flat2) - longint'(t)) + f2 * (longint'(t) - longint'(t_flat1));
        if (den < 0) begin
          den = -den;
          num = -num;
        end
      end
      if (num <= 0) begin
        r.status = ffln_pkg::ST_BAD_REF;
      end else begin
        d = log2_q24(num) - log2_q24(den * c);
        neg = d < 0;
        mag = longint'(neg ? -d : d) * longint'(ffln_pkg::LN2_Q32);
        q = (mag + (64'd1 << 39)) >> 40;
        if (q > 64'd8388608) q = 64'd8388608;
        att = neg ? -longint'(q) : longint'(q);
        if (att > ATT_HI) att = ATT_HI;
        if (att < ATT_LO) att = ATT_LO;
      end
    end
    r.att = att[23:0];
    return r;
  endfunction

  // model update at an accepted transfer
  function automatic void track_item(ffln_pkg::func_e f, logic [11:0] idx, logic [15:0] val,
                                     logic [31:0] t, logic last);
    atten_t r;
    case (f)
      ffln_pkg::FUNC_DARK: begin
        dark_px[idx] = val;
        dark_set[idx] = 1'b1;
      end
      ffln_pkg::FUNC_FLAT_BEFORE: begin
        flat1_px[idx] = val;
        flat1_set[idx] = 1'b1;
        t_flat1 = t;
      end
      ffln_pkg::FUNC_FLAT_AFTER: begin
        flat2_px[idx] = val;
        flat2_set[idx] = 1'b1;
        t_flat2 = t;
      end
      default: begin
        r = attenuation_of(idx, val, t, last);
        atten_q.push_back(r);
        n_proj++;
        if (r.status == ffln_pkg::ST_BLACK) n_black++;
        if (r.status == ffln_pkg::ST_BAD_REF) n_badref++;
      end
    endcase
    if (f != ffln_pkg::FUNC_PROJ) begin
      n_store++;
      if (dark_set[idx] && flat1_set[idx] && flat2_set[idx] && !in_ready_pool[idx]) begin
        in_ready_pool[idx] = 1'b1;
        ready_idx.push_back(idx);
      end
    end
  endfunction

  // one input transfer, with an optional random gap first
  task automatic send_item(ffln_pkg::func_e f, logic [11:0] idx, logic [15:0] val,
                           logic [31:0] t, logic last);
    int unsigned gap;
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    func_i = f;
    pixel_index_i = idx;
    pixel_value_i = val;
    shot_time_i = t;
    last_in_row_i = last;
    do @(posedge clk_i); while (in_stall_o);
    track_item(f, idx, val, t, last);
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_results();
    idle_input();
    while (atten_q.size() != 0) @(posedge clk_i);
    // store items give no result: let the pipeline settle
    repeat (40) @(posedge clk_i);
  endtask

  task automatic load_pixel(logic [11:0] idx, logic [15:0] dk, logic [15:0] fb,
                            logic [15:0] fa, logic [31:0] tb, logic [31:0] ta);
    send_item(ffln_pkg::FUNC_DARK, idx, dk, $urandom, 1'b0);
    send_item(ffln_pkg::FUNC_FLAT_BEFORE, idx, fb, tb, 1'b0);
    send_item(ffln_pkg::FUNC_FLAT_AFTER, idx, fa, ta, 1'b1);
  endtask

  // field extremes and each special case
  task automatic test_directed();
    load_pixel(12'd0, 16'd0, 16'hFFFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFF);
    send_item(ffln_pkg::FUNC_PROJ, 12'd0, 16'd1, 32'd0, 1'b0);
    send_item(ffln_pkg::FUNC_PROJ, 12'd0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(ffln_pkg::FUNC_PROJ, 12'd0, 16'd0, 32'h8000_0000, 1'b0);
    load_pixel(12'd4095, 16'd1000, 16'd500, 16'd40000, 32'd100, 32'd100);
    // equal flat times use flat-before, which is below dark here: bad reference
    send_item(ffln_pkg::FUNC_PROJ, 12'd4095, 16'd2000, 32'd7, 1'b1);
    // pixel equal to dark and below it: black
    send_item(ffln_pkg::FUNC_PROJ, 12'd4095, 16'd1000, 32'd7, 1'b0);
    send_item(ffln_pkg::FUNC_PROJ, 12'd4095, 16'd999, 32'd7, 1'b0);
    load_pixel(12'h555, 16'd10, 16'd30000, 16'd20000, 32'd5000, 32'd1000);
    // reversed times, interpolation and extrapolation on both sides
    send_item(ffln_pkg::FUNC_PROJ, 12'h555, 16'd15000, 32'd3000, 1'b0);
    send_item(ffln_pkg::FUNC_PROJ, 12'h555, 16'd11, 32'hFFFF_FFFF, 1'b1);
    send_item(ffln_pkg::FUNC_PROJ, 12'h555, 16'd65535, 32'd0, 1'b0);
    load_pixel(12'hAAA, 16'd0, 16'd1, 16'd65535, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_item(ffln_pkg::FUNC_PROJ, 12'hAAA, 16'd1, 32'd0, 1'b1);
    send_item(ffln_pkg::FUNC_PROJ, 12'hAAA, 16'd65535, 32'hFFFF_FFFE, 1'b0);
    wait_results();
  endtask

  function automatic logic [31:0] pick_time(logic [31:0] base);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return base;
      default: return base + $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  // mostly projections over loaded pixels, with store rewrites mixed in
  task automatic run_random(int unsigned n);
    logic [11:0]     idx;
    logic [15:0]     val, dk;
    logic [31:0]     base;
    ffln_pkg::func_e f;
    base = $urandom;
    for (int unsigned i = 0; i < n; i++) begin
      if (ready_idx.size() == 0 || $urandom_range(0, 4) == 0) begin
        f = ffln_pkg::func_e'($urandom_range(0, 2));
        idx = ($urandom_range(0, 1) == 0 && ready_idx.size() != 0) ?
              ready_idx[$urandom_range(0, ready_idx.size() - 1)] : 12'($urandom);
        if (!dark_set[idx] || !flat1_set[idx] || !flat2_set[idx]) begin
          load_pixel(idx, 16'($urandom_range(0, 3000)), 16'($urandom), 16'($urandom),
                     pick_time(base), pick_time(base));
          continue;
        end
        send_item(f, idx,
                  (f == ffln_pkg::FUNC_DARK) ? 16'($urandom_range(0, 3000)) : 16'($urandom),
                  pick_time(base), 1'($urandom_range(0, 1)));
      end else begin
        idx = ready_idx[$urandom_range(0, ready_idx.size() - 1)];
        dk = dark_px[idx];
        val = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, dk)) : 16'($urandom);
        send_item(ffln_pkg::FUNC_PROJ, idx, val, pick_time(base), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 80; i++)
      send_item(ffln_pkg::FUNC_PROJ, ready_idx[$urandom_range(0, ready_idx.size() - 1)],
                16'($urandom), $urandom, 1'($urandom_range(0, 1)));
    wait_results();
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate();
    send_gaps = 1'b0;
    recv_stalls = 1'b0;
    run_random(90);
    wait_results();
  endtask

  // receiver stall bursts and the long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall_i = 1'b1;
        repeat (300) @(negedge clk_i);
        out_stall_i = 1'b0;
        long_hold = 1'b0;
      end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // result check on every output transfer
  always @(posedge clk_i) begin
    atten_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (atten_q.size() == 0) begin
        $display("%0t: unexpected result att=%h status=%0d last=%0b", $realtime,
                 attenuation_o, pixel_status_o, last_of_row_o);
        mismatches++;
      end else begin
        exp_r = atten_q.pop_front();
        n_checked++;
        if (attenuation_o !== exp_r.att) begin
          $display("%0t: attenuation expected %h actual %h", $realtime, exp_r.att,
                   attenuation_o);
          mismatches++;
        end
        if (pixel_status_o !== exp_r.status) begin
          $display("%0t: pixel_status expected %0d actual %0d", $realtime, exp_r.status,
                   pixel_status_o);
          mismatches++;
        end
        if (last_of_row_o !== exp_r.last) begin
          $display("%0t: last_of_row expected %0b actual %0b", $realtime, exp_r.last,
                   last_of_row_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $realtime, atten_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    run_random(190);
    // sender pause until all results are back
    wait_results();
    run_random(190);
    test_backpressure();
    test_full_rate();
    if (atten_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, atten_q.size());
      mismatches++;
    end
    $display("covered %0d store transfers and %0d projections (%0d black, %0d bad reference)",
             n_store, n_proj, n_black, n_badref);
    $display("%0d results checked over %0d cycles, %0d mismatches", n_checked, cycles,
             mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
